>>> design/amap_pkg.sv
// ----------------------------------------------------------------------------
// Allocation map engine package
// Shared types and fixed widths for the status map, the scan sequencer and
// the top level.
// ----------------------------------------------------------------------------
package amap_pkg;

    localparam int ADDR_W = 10;  // request address and skip address
    localparam int CODE_W = 4;   // one status code
    localparam int LEN_W  = 11;  // region size, target and result length
    localparam int POS_W  = 11;  // scan position, never passes the region size
    localparam int CNT_W  = 12;  // gap count, may pass the target after a skip

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SEG   = 2'd2,
        CMD_GAP   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [LEN_W-1:0]  size;        // region size already capped to the map depth
        logic [CODE_W-1:0] free_code;
        logic [CODE_W-1:0] start_code;
        logic [CODE_W-1:0] cont_code;
    } t_cfg;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] address;
        logic [CODE_W-1:0] code_in;
        logic [LEN_W-1:0]  target;
        logic              skip_on;
        logic [ADDR_W-1:0] skip_addr;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } t_rsp;

    typedef struct packed {
        logic             pos_in;    // position lies inside the region
        logic             is_free;
        logic             is_start;
        logic             is_cont;
        logic             at_skip;   // position is the segment to pass over
        logic             cnt_hit;   // count has reached the target
        logic [POS_W-1:0] pos_nxt;
        logic [CNT_W-1:0] cnt_nxt;
    } t_step;

endpackage

>>> design/amap_mem.sv
// ----------------------------------------------------------------------------
// Allocation map status memory
// One code per managed byte, one write and one registered read per cycle.
// After reset a sweep writes zero into every entry.
// ----------------------------------------------------------------------------
module amap_mem
    import amap_pkg::*;
#(
    parameter int unsigned REGION_BYTES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [$clog2(REGION_BYTES)-1:0]   i_wr_addr,
    input  logic [CODE_W-1:0]                 i_wr_data,
    input  logic [$clog2(REGION_BYTES)-1:0]   i_rd_addr,
    output logic [CODE_W-1:0]                 o_rd_data,
    output logic                              o_busy
);

    localparam int unsigned AW = $clog2(REGION_BYTES);

    logic [CODE_W-1:0] r_mem [REGION_BYTES];
    logic [CODE_W-1:0] r_rd_data;
    logic              r_clr_busy;
    logic [AW-1:0]     r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(REGION_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

>>> design/amap_step.sv
// ----------------------------------------------------------------------------
// Allocation map scan step unit
// Classifies the code at the current scan position and forms the next
// position and count. Shared by every command that walks the map.
// ----------------------------------------------------------------------------
module amap_step
    import amap_pkg::*;
(
    input  t_cfg              i_cfg,
    input  logic [POS_W-1:0]  i_pos,
    input  logic [CNT_W-1:0]  i_cnt,
    input  logic [CODE_W-1:0] i_data,
    input  logic [LEN_W-1:0]  i_target,
    input  logic              i_skip_on,
    input  logic [ADDR_W-1:0] i_skip_addr,
    output t_step             o_step
);

    always_comb begin
        o_step.pos_in   = i_pos < i_cfg.size;
        o_step.is_free  = i_data == i_cfg.free_code;
        o_step.is_start = i_data == i_cfg.start_code;
        o_step.is_cont  = i_data == i_cfg.cont_code;
        o_step.at_skip  = i_skip_on && (i_pos == POS_W'(i_skip_addr));
        o_step.cnt_hit  = i_cnt >= CNT_W'(i_target);
        o_step.pos_nxt  = i_pos + POS_W'(1);
        o_step.cnt_nxt  = i_cnt + CNT_W'(1);
    end

endmodule

>>> design/amap_seq.sv
// ----------------------------------------------------------------------------
// Allocation map command sequencer
// Runs one command at a time. Scans read the map one entry per cycle and
// drive the shared step unit to decide when the walk ends.
// ----------------------------------------------------------------------------
module amap_seq
    import amap_pkg::*;
#(
    parameter int unsigned REGION_BYTES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_busy,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  t_req                              i_req,
    input  t_cfg                              i_cfg,
    output logic                              o_wr_en,
    output logic [$clog2(REGION_BYTES)-1:0]   o_wr_addr,
    output logic [CODE_W-1:0]                 o_wr_data,
    output logic [$clog2(REGION_BYTES)-1:0]   o_rd_addr,
    input  logic [CODE_W-1:0]                 i_rd_data,
    output logic                              o_rsp_push,
    input  logic                              i_rsp_room,
    output t_rsp                              o_rsp
);

    localparam int unsigned AW = $clog2(REGION_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SEG_HEAD,
        ST_SEG_RUN,
        ST_GAP_RUN,
        ST_SKIP_RUN,
        ST_RESP
    } t_state;

    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [LEN_W-1:0]  r_target, n_target;
    logic              r_skip_on, n_skip_on;
    logic [ADDR_W-1:0] r_skip_addr, n_skip_addr;
    t_rsp              r_rsp, n_rsp;
    t_step             step;
    logic              accept;

    amap_step u_step (
        .i_cfg       (i_cfg),
        .i_pos       (r_pos),
        .i_cnt       (r_cnt),
        .i_data      (i_rd_data),
        .i_target    (r_target),
        .i_skip_on   (r_skip_on),
        .i_skip_addr (r_skip_addr),
        .o_step      (step)
    );

    assign o_req_ready = (r_state == ST_IDLE) && !i_busy;
    assign accept      = i_req_valid && o_req_ready;
    assign o_wr_addr   = AW'(i_req.address);
    assign o_wr_data   = i_req.code_in;
    assign o_rsp_push  = (r_state == ST_RESP) && i_rsp_room;
    assign o_rsp       = r_rsp;

    // Outside idle the read port fetches the entry after the current position,
    // so the data for a position arrives in the cycle that position is current.
    assign o_rd_addr = (r_state == ST_IDLE) ? AW'(i_req.address) : AW'(step.pos_nxt);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_target    = r_target;
        n_skip_on   = r_skip_on;
        n_skip_addr = r_skip_addr;
        n_rsp       = r_rsp;
        o_wr_en     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pos       = POS_W'(i_req.address);
                    n_cnt       = '0;
                    n_target    = i_req.target;
                    n_skip_on   = i_req.skip_on;
                    n_skip_addr = i_req.skip_addr;
                    n_rsp       = '0;
                    if (POS_W'(i_req.address) >= i_cfg.size) begin
                        n_state = ST_RESP;
                    end else begin
                        n_rsp.ok = 1'b1;
                        unique case (i_req.cmd)
                            CMD_WRITE: begin
                                o_wr_en = 1'b1;
                                n_state = ST_RESP;
                            end
                            CMD_READ: n_state = ST_RD_WAIT;
                            CMD_SEG:  n_state = ST_SEG_HEAD;
                            CMD_GAP:  n_state = ST_GAP_RUN;
                        endcase
                    end
                end
            end
            ST_RD_WAIT: begin
                n_rsp.code = i_rd_data;
                n_state    = ST_RESP;
            end
            ST_SEG_HEAD: begin
                if (step.is_start) begin
                    n_cnt   = CNT_W'(1);
                    n_pos   = step.pos_nxt;
                    n_state = ST_SEG_RUN;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_SEG_RUN: begin
                if (step.pos_in && step.is_cont) begin
                    n_cnt = step.cnt_nxt;
                    n_pos = step.pos_nxt;
                end else begin
                    n_rsp.length = LEN_W'(r_cnt);
                    n_state      = ST_RESP;
                end
            end
            ST_GAP_RUN, ST_SKIP_RUN: begin
                // While passing over the named segment, continuation entries
                // add to the count without a target check. The first entry
                // after it is judged by the ordinary gap rules.
                if ((r_state == ST_SKIP_RUN) && step.pos_in && step.is_cont) begin
                    n_cnt = step.cnt_nxt;
                    n_pos = step.pos_nxt;
                end else begin
                    priority if (step.cnt_hit) begin
                        n_rsp.length = r_target;
                        n_state      = ST_RESP;
                    end else if (!step.pos_in) begin
                        n_rsp.length = LEN_W'(r_cnt);
                        n_state      = ST_RESP;
                    end else if (step.is_free) begin
                        n_cnt   = step.cnt_nxt;
                        n_pos   = step.pos_nxt;
                        n_state = ST_GAP_RUN;
                    end else if (step.at_skip && step.is_start) begin
                        n_cnt   = step.cnt_nxt;
                        n_pos   = step.pos_nxt;
                        n_state = ST_SKIP_RUN;
                    end else begin
                        n_rsp.length = LEN_W'(r_cnt);
                        n_state      = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (i_rsp_room) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pos       <= n_pos;
        r_cnt       <= n_cnt;
        r_target    <= n_target;
        r_skip_on   <= n_skip_on;
        r_skip_addr <= n_skip_addr;
        r_rsp       <= n_rsp;
    end

endmodule

>>> design/allocation_map_engine_unit.sv
// ----------------------------------------------------------------------------
// Allocation map engine
// Status code table for a managed byte region with write, read, segment size
// and gap size commands, configured over an APB-style register port.
//
//   Channel   Direction  Handshake                   Payload
//   request   in         i_req_valid / o_req_ready   command, address, code_in,
//                                                    target_length, skip_*
//   response  out        o_rsp_valid / i_rsp_ready   ok, code_out, length_out
//   config    in         psel, penable, pwrite       paddr, pwdata, prdata
//
// A write or an out-of-region request goes from acceptance to the response
// state, a read waits for the registered map read, a segment size checks the
// head entry and walks the segment, and a gap size walks the entries visited;
// the single map read port walks one entry per cycle. After reset a clearing
// pass fills the map with zeros with o_req_ready low; register writes are
// taken throughout. A request is taken while an earlier response still waits
// in the output register; the sequencer holds its result until that slot frees.
// ----------------------------------------------------------------------------
module allocation_map_engine_unit
    import amap_pkg::*;
#(
    parameter int unsigned REGION_BYTES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic [1:0]         i_command,
    input  logic [ADDR_W-1:0]  i_address,
    input  logic [CODE_W-1:0]  i_code_in,
    input  logic [LEN_W-1:0]   i_target_length,
    input  logic               i_skip_valid,
    input  logic [ADDR_W-1:0]  i_skip_address,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output logic               o_ok,
    output logic [CODE_W-1:0]  o_code_out,
    output logic [LEN_W-1:0]   o_length_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned AW       = $clog2(REGION_BYTES);
    localparam int unsigned SIZE_CAP = (REGION_BYTES < 2047) ? REGION_BYTES : 2047;

    localparam logic [1:0] REG_REGION_SIZE = 2'd0;
    localparam logic [1:0] REG_FREE_CODE   = 2'd1;
    localparam logic [1:0] REG_START_CODE  = 2'd2;
    localparam logic [1:0] REG_CONT_CODE   = 2'd3;

    logic [LEN_W-1:0]  r_region_size;
    logic [CODE_W-1:0] r_free_code;
    logic [CODE_W-1:0] r_start_code;
    logic [CODE_W-1:0] r_cont_code;
    logic              r_rsp_valid;
    t_rsp              r_rsp;

    t_cfg              cfg;
    t_req              req;
    t_rsp              seq_rsp;
    logic              cfg_wr;
    logic              rsp_room;
    logic              rsp_push;
    logic              clr_busy;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [CODE_W-1:0] mem_wr_data;
    logic [AW-1:0]     mem_rd_addr;
    logic [CODE_W-1:0] mem_rd_data;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_size <= LEN_W'(1024);
            r_free_code   <= CODE_W'(0);
            r_start_code  <= CODE_W'(1);
            r_cont_code   <= CODE_W'(2);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_REGION_SIZE: r_region_size <= pwdata[LEN_W-1:0];
                REG_FREE_CODE:   r_free_code   <= pwdata[CODE_W-1:0];
                REG_START_CODE:  r_start_code  <= pwdata[CODE_W-1:0];
                REG_CONT_CODE:   r_cont_code   <= pwdata[CODE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_REGION_SIZE: prdata = {{(32-LEN_W){1'b0}}, r_region_size};
            REG_FREE_CODE:   prdata = {{(32-CODE_W){1'b0}}, r_free_code};
            REG_START_CODE:  prdata = {{(32-CODE_W){1'b0}}, r_start_code};
            REG_CONT_CODE:   prdata = {{(32-CODE_W){1'b0}}, r_cont_code};
        endcase
    end

    // The usable region never extends past the end of the map.
    always_comb begin
        cfg.size       = (r_region_size > LEN_W'(SIZE_CAP)) ? LEN_W'(SIZE_CAP) : r_region_size;
        cfg.free_code  = r_free_code;
        cfg.start_code = r_start_code;
        cfg.cont_code  = r_cont_code;
    end

    always_comb begin
        req.cmd       = t_cmd'(i_command);
        req.address   = i_address;
        req.code_in   = i_code_in;
        req.target    = i_target_length;
        req.skip_on   = i_skip_valid;
        req.skip_addr = i_skip_address;
    end

    // ---------------- datapath ----------------
    amap_mem #(
        .REGION_BYTES (REGION_BYTES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .o_busy    (clr_busy)
    );

    amap_seq #(
        .REGION_BYTES (REGION_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_busy      (clr_busy),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (req),
        .i_cfg       (cfg),
        .o_wr_en     (mem_wr_en),
        .o_wr_addr   (mem_wr_addr),
        .o_wr_data   (mem_wr_data),
        .o_rd_addr   (mem_rd_addr),
        .i_rd_data   (mem_rd_data),
        .o_rsp_push  (rsp_push),
        .i_rsp_room  (rsp_room),
        .o_rsp       (seq_rsp)
    );

    // ---------------- response register ----------------
    assign rsp_room = !r_rsp_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (rsp_push) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
        if (rsp_push) begin
            r_rsp <= seq_rsp;
        end
    end

    assign o_rsp_valid  = r_rsp_valid;
    assign o_ok         = r_rsp.ok;
    assign o_code_out   = r_rsp.code;
    assign o_length_out = r_rsp.length;

    // ---------------- assertions ----------------
    a_no_req_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> !clr_busy)
        else $error("request port open while the map is being cleared");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("sequencer took a second request without working the first");

    a_reject_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_ok) |-> (o_code_out == '0 && o_length_out == '0))
        else $error("out-of-region response carries a nonzero result");

    a_length_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_length_out <= r_region_size))
        else $error("response length exceeds the region size");

endmodule
